@@ rtl/spds_pkg.sv @@
// Shared types and character codes for the s-expression paren depth scanner.
package spds_pkg;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BAR    = 8'h7C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_NL     = 8'h0A;

  localparam int OUT_DEPTH_BITS = 16;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       last_byte;
  } req_item_t;

  typedef struct packed {
    logic signed [OUT_DEPTH_BITS-1:0] depth;
    logic                             inside_string;
    logic                             inside_comment;
    logic                             needs_more;
  } rsp_item_t;

  typedef struct packed {
    logic string_mode;
    logic escape_pending;
    logic line_comment_mode;
    logic hash_pending;
    logic bar_pending;
  } scan_flags_t;

endpackage

@@ rtl/spds_step.sv @@
// Per-byte scanner update: next flags, depth and nesting, plus the result item.
module spds_step #(
  parameter int DEPTH_BITS = 16,
  parameter int NEST_BITS  = 8
) (
  input  spds_pkg::req_item_t          item,
  input  spds_pkg::scan_flags_t        flags,
  input  logic signed [DEPTH_BITS-1:0] paren_count,
  input  logic [NEST_BITS-1:0]         block_nesting,
  output spds_pkg::scan_flags_t        flags_next,
  output logic signed [DEPTH_BITS-1:0] paren_count_next,
  output logic [NEST_BITS-1:0]         block_nesting_next,
  output spds_pkg::rsp_item_t          result
);
  import spds_pkg::*;

  localparam int WIDE_BITS = (DEPTH_BITS > OUT_DEPTH_BITS) ? DEPTH_BITS : OUT_DEPTH_BITS;
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic [NEST_BITS-1:0]         NEST_MAX  = {NEST_BITS{1'b1}};
  localparam logic signed [WIDE_BITS-1:0]  SHOW_MAX  = WIDE_BITS'(32767);
  localparam logic signed [WIDE_BITS-1:0]  SHOW_MIN  = -WIDE_BITS'(32768);

  logic [7:0]                   c;
  scan_flags_t                  f;
  logic signed [DEPTH_BITS-1:0] p;
  logic [NEST_BITS-1:0]         n;
  logic signed [WIDE_BITS-1:0]  wide;
  logic signed [WIDE_BITS-1:0]  shown;

  assign c = item.text_byte;

  always_comb begin
    f = flags;
    p = paren_count;
    n = block_nesting;
    if (flags.line_comment_mode) begin
      if (c == CH_NL) f.line_comment_mode = 1'b0;
    end else if (block_nesting != '0) begin
      if (flags.hash_pending && c == CH_BAR) begin
        f.hash_pending = 1'b0;
        f.bar_pending  = 1'b0;
        if (n != NEST_MAX) n = n + 1'b1;
      end else if (flags.bar_pending && c == CH_HASH) begin
        f.hash_pending = 1'b0;
        f.bar_pending  = 1'b0;
        n = n - 1'b1;
      end else begin
        f.hash_pending = (c == CH_HASH);
        f.bar_pending  = (c == CH_BAR);
      end
    end else if (flags.string_mode) begin
      if (flags.escape_pending) f.escape_pending = 1'b0;
      else if (c == CH_BSLASH) f.escape_pending = 1'b1;
      else if (c == CH_QUOTE) f.string_mode = 1'b0;
    end else if (flags.hash_pending && c == CH_BAR) begin
      f.hash_pending = 1'b0;
      if (n != NEST_MAX) n = n + 1'b1;
    end else begin
      f.hash_pending = 1'b0;
      case (c)
        CH_QUOTE: f.string_mode = 1'b1;
        CH_SEMI:  f.line_comment_mode = 1'b1;
        CH_HASH:  f.hash_pending = 1'b1;
        CH_OPEN:  if (p != DEPTH_MAX) p = p + 1'b1;
        CH_CLOSE: if (p != DEPTH_MIN) p = p - 1'b1;
        default:  ;
      endcase
    end
  end

  // clamp a wide count to the 16-bit result range
  always_comb begin
    wide = WIDE_BITS'(p);
    if (wide > SHOW_MAX) shown = SHOW_MAX;
    else if (wide < SHOW_MIN) shown = SHOW_MIN;
    else shown = wide;
  end

  assign result.depth          = shown[OUT_DEPTH_BITS-1:0];
  assign result.inside_string  = f.string_mode;
  assign result.inside_comment = f.line_comment_mode || (n != '0);
  assign result.needs_more     = (p > 0);

  // drop all state after the last byte of an expression
  assign flags_next         = item.last_byte ? '0 : f;
  assign paren_count_next   = item.last_byte ? '0 : p;
  assign block_nesting_next = item.last_byte ? '0 : n;

endmodule

@@ rtl/sexpr_paren_depth_scanner_core.sv @@
// Top level of the s-expression paren depth scanner: input, state and result registers.
//
//   channel  signals                    payload      direction
//   req      req_valid / req_ready      req (byte)   into block
//   rsp      rsp_valid / rsp_ready      rsp (depth)  out of block
//
// One item per cycle sustained while results are taken; each item passes through
// the input register, then the result register. The scan state updates as an
// item moves into the result register. Reset (rst, synchronous) empties both
// registers and clears the scan state. A stalled result holds the result
// register; the input register still drains into it once it empties.
module sexpr_paren_depth_scanner_core #(
  parameter int DEPTH_BITS = 16,
  parameter int NEST_BITS  = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  spds_pkg::req_item_t req,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output spds_pkg::rsp_item_t rsp
);
  import spds_pkg::*;

  logic                         held_valid;
  req_item_t                    held;
  scan_flags_t                  flags;
  logic signed [DEPTH_BITS-1:0] paren_count;
  logic [NEST_BITS-1:0]         block_nesting;
  scan_flags_t                  flags_next;
  logic signed [DEPTH_BITS-1:0] paren_count_next;
  logic [NEST_BITS-1:0]         block_nesting_next;
  rsp_item_t                    result;
  logic                         advance;

  assign advance   = held_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !held_valid || advance;

  spds_step #(
    .DEPTH_BITS(DEPTH_BITS),
    .NEST_BITS (NEST_BITS)
  ) u_step (
    .item              (held),
    .flags             (flags),
    .paren_count       (paren_count),
    .block_nesting     (block_nesting),
    .flags_next        (flags_next),
    .paren_count_next  (paren_count_next),
    .block_nesting_next(block_nesting_next),
    .result            (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid    <= 1'b0;
      rsp_valid     <= 1'b0;
      flags         <= '0;
      paren_count   <= '0;
      block_nesting <= '0;
    end else begin
      if (req_ready) held_valid <= req_valid;
      if (advance) begin
        rsp_valid     <= 1'b1;
        flags         <= flags_next;
        paren_count   <= paren_count_next;
        block_nesting <= block_nesting_next;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) held <= req;
    if (advance) rsp <= result;
  end

endmodule

@@ verif/tb_sexpr_paren_depth_scanner_core.sv @@
// Self-checking testbench for the s-expression paren depth scanner core.
module tb_sexpr_paren_depth_scanner_core;
  import spds_pkg::*;

  localparam int DEPTH_BITS = 16;
  localparam int NEST_BITS  = 8;
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
  localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
  localparam logic [NEST_BITS-1:0] NEST_MAX = {NEST_BITS{1'b1}};
  localparam int RANDOM_ITEMS = 700;
  localparam int IDLE_PCT     = 13;
  localparam int HOLD_CYCLES  = 400;
  localparam int LIMIT_CYCLES = 1000000;

  // Tracks scan state from accepted bytes and holds the results still to arrive.
  class depth_scoreboard;
    logic signed [DEPTH_BITS-1:0] paren_count;
    logic                         str_mode;
    logic                         esc_pend;
    logic                         line_mode;
    logic [NEST_BITS-1:0]         nest;
    logic                         hash_pend;
    logic                         bar_pend;
    rsp_item_t                    expected_q[$];
    int                           mismatches;
    int                           checked;

    function new();
      clear_scan();
      mismatches = 0;
      checked = 0;
    endfunction

    function void clear_scan();
      paren_count = '0;
      str_mode = 1'b0;
      esc_pend = 1'b0;
      line_mode = 1'b0;
      nest = '0;
      hash_pend = 1'b0;
      bar_pend = 1'b0;
    endfunction

    function rsp_item_t scan_byte(req_item_t it);
      logic [7:0] c;
      rsp_item_t  r;
      c = it.text_byte;
      if (line_mode) begin
        if (c == CH_NL) line_mode = 1'b0;
      end else if (nest != '0) begin
        if (hash_pend && c == CH_BAR) begin
          hash_pend = 1'b0;
          bar_pend = 1'b0;
          if (nest != NEST_MAX) nest = nest + 1'b1;
        end else if (bar_pend && c == CH_HASH) begin
          hash_pend = 1'b0;
          bar_pend = 1'b0;
          nest = nest - 1'b1;
        end else begin
          hash_pend = (c == CH_HASH);
          bar_pend = (c == CH_BAR);
        end
      end else if (str_mode) begin
        if (esc_pend) esc_pend = 1'b0;
        else if (c == CH_BSLASH) esc_pend = 1'b1;
        else if (c == CH_QUOTE) str_mode = 1'b0;
      end else if (hash_pend && c == CH_BAR) begin
        hash_pend = 1'b0;
        if (nest != NEST_MAX) nest = nest + 1'b1;
      end else begin
        hash_pend = 1'b0;
        case (c)
          CH_QUOTE: str_mode = 1'b1;
          CH_SEMI:  line_mode = 1'b1;
          CH_HASH:  hash_pend = 1'b1;
          CH_OPEN:  if (paren_count != DEPTH_MAX) paren_count = paren_count + 1'b1;
          CH_CLOSE: if (paren_count != DEPTH_MIN) paren_count = paren_count - 1'b1;
          default: ;
        endcase
      end
      r.depth = paren_count;
      r.inside_string = str_mode;
      r.inside_comment = line_mode || (nest != '0);
      r.needs_more = (paren_count > 0);
      if (it.last_byte) clear_scan();
      return r;
    endfunction

    function void note_byte(req_item_t it);
      expected_q = {expected_q, scan_byte(it)};
    endfunction

    function void check_result(rsp_item_t got);
      rsp_item_t exp;
      if (expected_q.size() == 0) begin
        $error("unexpected result: depth %0d", $signed(got.depth));
        mismatches++;
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.depth !== exp.depth) begin
        $error("depth: expected %0d, got %0d", $signed(exp.depth), $signed(got.depth));
        mismatches++;
      end
      if (got.inside_string !== exp.inside_string) begin
        $error("inside_string: expected %0b, got %0b", exp.inside_string, got.inside_string);
        mismatches++;
      end
      if (got.inside_comment !== exp.inside_comment) begin
        $error("inside_comment: expected %0b, got %0b", exp.inside_comment, got.inside_comment);
        mismatches++;
      end
      if (got.needs_more !== exp.needs_more) begin
        $error("needs_more: expected %0b, got %0b", exp.needs_more, got.needs_more);
        mismatches++;
      end
    endfunction
  endclass

  logic      clk;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_ready;
  req_item_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  rsp_item_t rsp;

  depth_scoreboard sb = new();
  bit idle_on = 1'b1;
  bit hold_request = 1'b0;
  int bytes_sent = 0;
  int cycles = 0;

  sexpr_paren_depth_scanner_core #(
    .DEPTH_BITS(DEPTH_BITS),
    .NEST_BITS (NEST_BITS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp      (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_sexpr_paren_depth_scanner_core: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_byte(req);
      if (rsp_valid && rsp_ready) sb.check_result(rsp);
    end
  end

  // Receiver: random backpressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, bit is_last);
    req_item_t it;
    while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
      req_valid <= 1'b0;
      req <= {8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))};
      @(posedge clk);
    end
    it.text_byte = b;
    it.last_byte = is_last;
    req_valid <= 1'b1;
    req <= it;
    do @(posedge clk); while (!req_ready);
    bytes_sent++;
  endtask

  task automatic send_text(string s, bit end_last);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], end_last && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] atom_char();
    logic [7:0] c;
    c = 8'($urandom_range(8'h61, 8'h7A));
    return c;
  endfunction

  // One lexical fragment: mostly well-formed pieces with random content, some noise.
  task automatic random_fragment();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 22) begin
      send_byte(CH_OPEN, 1'b0);
    end else if (kind < 40) begin
      send_byte(CH_CLOSE, $urandom_range(0, 99) < 15);
    end else if (kind < 52) begin
      n = $urandom_range(1, 5);
      repeat (n) send_byte(atom_char(), 1'b0);
      send_byte(8'h20, 1'b0);
    end else if (kind < 64) begin
      send_byte(CH_QUOTE, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) begin
          send_byte(CH_BSLASH, 1'b0);
          send_byte(8'($urandom_range(0, 255)), 1'b0);
        end else begin
          send_byte($urandom_range(0, 1) ? CH_OPEN : atom_char(), 1'b0);
        end
      end
      send_byte(CH_QUOTE, 1'b0);
    end else if (kind < 71) begin
      send_byte(CH_SEMI, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) send_byte(8'($urandom_range(0, 255)), 1'b0);
      send_byte(CH_NL, 1'b0);
    end else if (kind < 81) begin
      send_byte(CH_HASH, 1'b0);
      send_byte(CH_BAR, 1'b0);
      n = $urandom_range(0, 6);
      repeat (n) begin
        case ($urandom_range(0, 5))
          0: send_byte(CH_HASH, 1'b0);
          1: send_byte(CH_BAR, 1'b0);
          2: send_byte(CH_OPEN, 1'b0);
          3: send_text("#|x|#", 1'b0);
          default: send_byte(8'($urandom_range(0, 255)), 1'b0);
        endcase
      end
      send_byte(CH_BAR, 1'b0);
      send_byte(CH_HASH, 1'b0);
    end else if (kind < 93) begin
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  initial begin
    int base;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: parens, strings with escapes, line and nested block comments,
    // broken markers, bar-hash outside a block, extreme bytes, pending at end.
    send_text(")))", 1'b0);
    send_text("((\"(\\\"x\"", 1'b0);
    send_text(";(\n", 1'b0);
    send_text("#|#|(|x|##x|#", 1'b0);
    send_text("|#)", 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(CH_HASH, 1'b1);
    send_text("\"\\", 1'b1);
    send_text("#|", 1'b1);

    // Saturate block nesting, drop a few levels, then end inside the comment.
    repeat (257) send_text("#|", 1'b0);
    repeat (3) send_text("|#", 1'b0);
    send_byte(CH_OPEN, 1'b0);
    send_byte(CH_CLOSE, 1'b1);

    base = bytes_sent;
    while (bytes_sent < base + RANDOM_ITEMS) begin
      if (bytes_sent - base > 100 && bytes_sent - base < 110) hold_request = 1'b1;
      idle_on = !(bytes_sent - base > 300 && bytes_sent - base < 550);
      random_fragment();
    end
    idle_on = 1'b1;
    req_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Scanned %0d bytes, checked %0d results: strings, comments, markers,",
             bytes_sent, sb.checked);
    $display("nesting saturation, random backpressure and a long output stall.");
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_sexpr_paren_depth_scanner_core: PASS");
    end else begin
      $display("tb_sexpr_paren_depth_scanner_core: FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/spds_pkg.sv
rtl/spds_step.sv
rtl/sexpr_paren_depth_scanner_core.sv
verif/tb_sexpr_paren_depth_scanner_core.sv
